@@ hw/rtl/hsv_to_rgb_pixel_convert_top_defines.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared assertion wrappers for the converter's checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_PIXEL_CONVERT_TOP_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_CONVERT_TOP_DEFINES_SVH

// Clocked assertion, quiet while reset is held
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well
`define HSVRGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, hue sector codes and pipeline control types.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // Color channel width and full scale
    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Width of a channel-by-channel product and of a divide-by-255 quotient
    localparam int PROD_W = 16;
    localparam int QUO_W  = 9;

    // Register stages from input beat to output beat
    localparam int NUM_STAGES = 6;

    // Hue sectors, sixths of a turn
    typedef enum logic [2:0] {
        SECTOR_RED_YEL = 3'd0,
        SECTOR_YEL_GRN = 3'd1,
        SECTOR_GRN_CYN = 3'd2,
        SECTOR_CYN_BLU = 3'd3,
        SECTOR_BLU_MAG = 3'd4,
        SECTOR_MAG_RED = 3'd5
    } sector_t;

    // Stage enables for the two-stage divide-by-255 unit
    typedef struct packed {
        logic en_est;
        logic en_fix;
    } div_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/hsvrgb_div255.sv @@
// ----------------------------------------------------------------------------
// Divide by 255, two pipeline stages
// Reciprocal estimate in the first stage, one compare-and-correct in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_div255 (
    input  wire logic                         aclk,
    input  wire hsvrgb_pkg::div_ctrl_t        ctrl,
    input  wire logic [hsvrgb_pkg::PROD_W-1:0] x_in,
    output logic      [hsvrgb_pkg::QUO_W-1:0]  q_out
);

    logic [hsvrgb_pkg::PROD_W-1:0] x_reg;
    logic [hsvrgb_pkg::QUO_W-1:0]  est_reg;
    logic [hsvrgb_pkg::QUO_W-1:0]  q_reg;

    logic [hsvrgb_pkg::PROD_W:0]   est_sum;
    logic [hsvrgb_pkg::PROD_W:0]   est_x255;
    logic [hsvrgb_pkg::PROD_W:0]   rem;
    logic [hsvrgb_pkg::QUO_W-1:0]  q_next;

    // Estimate x*257/65536, which undershoots x/255 by at most one
    assign est_sum = {1'b0, x_in} + {9'b0, x_in[hsvrgb_pkg::PROD_W-1:8]};

    always_ff @(posedge aclk) begin
        if (ctrl.en_est) begin
            x_reg   <= x_in;
            est_reg <= est_sum[hsvrgb_pkg::PROD_W:8];
        end
    end

    // Bump the estimate when the remainder still holds a whole 255
    always_comb begin
        est_x255 = {est_reg, 8'b0} - {8'b0, est_reg};
        rem      = {1'b0, x_reg} - est_x255;
        q_next   = (rem >= 17'd255) ? est_reg + 9'd1 : est_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_fix) begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hsv_to_rgb_pixel_convert_top.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB pixel converter
// Six-sector fixed-point HSV to RGB conversion on a streaming pixel path.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one HSV pixel per beat: hue as a fraction of a
//   turn (HUE_BITS bits), saturation and brightness as 0..255 (255 = 1.0).
//   Master channel m_* returns one RGB pixel per input beat, in order.
//   Throughput: one pixel per clock while m_tready is high. The pipeline
//   has six register stages: hue sector split, p/q/t numerators,
//   brightness products, two stages of divide by 255, and the sector
//   select into the output register.
//   Stalls: each stage holds while it is full and the stage after it holds,
//   so bubbles collapse; s_tready stays high whenever m_tready is high or
//   any stage is empty. Nothing is dropped or repeated under backpressure.
//   Reset (aresetn low, synchronous) empties every stage; no pixel is
//   output until new beats arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_convert_top #(
    parameter int HUE_BITS = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // hue [HUE_BITS-1:0], saturation [+7:+0], brightness [+15:+8], zero fill
    input  wire logic [((HUE_BITS + 16 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [23:0]                                 m_tdata
);

    localparam int CW = hsvrgb_pkg::CH_W;
    localparam int NS = hsvrgb_pkg::NUM_STAGES;
    localparam int AW = HUE_BITS + 8;
    localparam int MW = HUE_BITS + 16;
    localparam logic [AW-1:0] FULL_SCALE = {8'd255, {HUE_BITS{1'b0}}};
    localparam logic [HUE_BITS:0] HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};

    // Saturate a quotient to the channel range
    function automatic logic [CW-1:0] clamp_ch(input logic [hsvrgb_pkg::QUO_W-1:0] val);
        logic [CW-1:0] res;
        res = (val > {1'b0, hsvrgb_pkg::CH_MAX}) ? hsvrgb_pkg::CH_MAX : val[CW-1:0];
        return res;
    endfunction

    // Input fields
    logic [HUE_BITS-1:0] in_hue;
    logic [CW-1:0]       in_sat;
    logic [CW-1:0]       in_val;

    assign in_hue = s_tdata[HUE_BITS-1:0];
    assign in_sat = s_tdata[HUE_BITS+7:HUE_BITS];
    assign in_val = s_tdata[HUE_BITS+15:HUE_BITS+8];

    // Stage valids and advance enables
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_tready = adv[0];

    // Stage 1: split hue*6 into sector and fraction, form V*(255-S)
    logic [HUE_BITS+2:0]       hue6;
    hsvrgb_pkg::sector_t       sec1_reg;
    logic [HUE_BITS-1:0]       frac1_reg;
    logic [CW-1:0]             sat1_reg;
    logic [CW-1:0]             val1_reg;
    logic [hsvrgb_pkg::PROD_W-1:0] pm1_reg;

    assign hue6 = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            sec1_reg  <= hsvrgb_pkg::sector_t'(hue6[HUE_BITS+2:HUE_BITS]);
            frac1_reg <= hue6[HUE_BITS-1:0];
            sat1_reg  <= in_sat;
            val1_reg  <= in_val;
            pm1_reg   <= in_val * (hsvrgb_pkg::CH_MAX - in_sat);
        end
    end

    // Stage 2: q and t numerators, 255*F - S*f and 255*F - S*(F-f)
    hsvrgb_pkg::sector_t       sec2_reg;
    logic [CW-1:0]             val2_reg;
    logic [hsvrgb_pkg::PROD_W-1:0] pm2_reg;
    logic [AW-1:0]             aq2_reg;
    logic [AW-1:0]             at2_reg;
    logic [HUE_BITS:0]         frac_rest;
    logic [AW-1:0]             sf_prod;
    logic [AW-1:0]             sr_prod;

    always_comb begin
        frac_rest = HUE_ONE - {1'b0, frac1_reg};
        sf_prod   = AW'(sat1_reg * frac1_reg);
        sr_prod   = AW'(sat1_reg * frac_rest);
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sec2_reg <= sec1_reg;
            val2_reg <= val1_reg;
            pm2_reg  <= pm1_reg;
            aq2_reg  <= FULL_SCALE - sf_prod;
            at2_reg  <= FULL_SCALE - sr_prod;
        end
    end

    // Stage 3: scale numerators by brightness
    hsvrgb_pkg::sector_t       sec3_reg;
    logic [CW-1:0]             val3_reg;
    logic [hsvrgb_pkg::PROD_W-1:0] pm3_reg;
    logic [MW-1:0]             mq3_reg;
    logic [MW-1:0]             mt3_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            sec3_reg <= sec2_reg;
            val3_reg <= val2_reg;
            pm3_reg  <= pm2_reg;
            mq3_reg  <= val2_reg * aq2_reg;
            mt3_reg  <= val2_reg * at2_reg;
        end
    end

    // Stages 4 and 5: drop the hue scale, then divide by 255
    hsvrgb_pkg::div_ctrl_t         div_ctrl;
    logic [hsvrgb_pkg::QUO_W-1:0]  p_quo;
    logic [hsvrgb_pkg::QUO_W-1:0]  q_quo;
    logic [hsvrgb_pkg::QUO_W-1:0]  t_quo;

    assign div_ctrl.en_est = adv[3];
    assign div_ctrl.en_fix = adv[4];

    hsvrgb_div255 u_div_p (
        .aclk  (aclk),
        .ctrl  (div_ctrl),
        .x_in  (pm3_reg),
        .q_out (p_quo)
    );

    hsvrgb_div255 u_div_q (
        .aclk  (aclk),
        .ctrl  (div_ctrl),
        .x_in  (mq3_reg[MW-1:HUE_BITS]),
        .q_out (q_quo)
    );

    hsvrgb_div255 u_div_t (
        .aclk  (aclk),
        .ctrl  (div_ctrl),
        .x_in  (mt3_reg[MW-1:HUE_BITS]),
        .q_out (t_quo)
    );

    hsvrgb_pkg::sector_t sec4_reg;
    hsvrgb_pkg::sector_t sec5_reg;
    logic [CW-1:0]       val4_reg;
    logic [CW-1:0]       val5_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            sec4_reg <= sec3_reg;
            val4_reg <= val3_reg;
        end
        if (adv[4]) begin
            sec5_reg <= sec4_reg;
            val5_reg <= val4_reg;
        end
    end

    // Stage 6: pick channels by sector; zero saturation falls out as p = q = t = V
    logic [CW-1:0] p_ch;
    logic [CW-1:0] q_ch;
    logic [CW-1:0] t_ch;
    logic [23:0]   rgb_next;
    logic [23:0]   rgb_reg;

    always_comb begin
        p_ch = clamp_ch(p_quo);
        q_ch = clamp_ch(q_quo);
        t_ch = clamp_ch(t_quo);
        case (sec5_reg)
            hsvrgb_pkg::SECTOR_RED_YEL: rgb_next = {p_ch, t_ch, val5_reg};
            hsvrgb_pkg::SECTOR_YEL_GRN: rgb_next = {p_ch, val5_reg, q_ch};
            hsvrgb_pkg::SECTOR_GRN_CYN: rgb_next = {t_ch, val5_reg, p_ch};
            hsvrgb_pkg::SECTOR_CYN_BLU: rgb_next = {val5_reg, q_ch, p_ch};
            hsvrgb_pkg::SECTOR_BLU_MAG: rgb_next = {val5_reg, p_ch, t_ch};
            hsvrgb_pkg::SECTOR_MAG_RED: rgb_next = {q_ch, p_ch, val5_reg};
            default:                    rgb_next = {q_ch, p_ch, val5_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            rgb_reg <= rgb_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = rgb_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hsvrgb_checker.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter port checker
// Watches the converter's stream ports and flags handshake and flow slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_pixel_convert_top_defines.svh"

module hsvrgb_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // Hold a stalled output beat and its pixel
    `HSVRGB_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "output beat dropped while stalled")
    `HSVRGB_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled output pixel changed")

    // Reset empties the pipeline
    `HSVRGB_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid right after reset")

    // A taking receiver never backs up the input side
    `HSVRGB_ASSERT_ALWAYS(a_no_false_stall, aclk, m_tready |-> s_tready, "input stalled while output drains")

endmodule

bind hsv_to_rgb_pixel_convert_top hsvrgb_checker u_hsvrgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/hsv_to_rgb_pixel_convert_top_tb.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB pixel converter testbench
// Sends HSV pixel beats into the converter and checks each RGB beat against
// a six-sector fixed-point predictor. A directed pass covers the sector
// edges, the extremes of each channel and zero saturation. Random streams
// follow, run with no idling, with sender gaps, with receiver stalls and
// with both.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_convert_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_W   = 16;
    localparam int S_DW    = ((HUE_W + 16 + 7) / 8) * 8;
    localparam int HUE_ONE = 1 << HUE_W;
    localparam int MAX_REPORTS = 50;

    // One input pixel, laid out as on s_tdata (last member in the low bits)
    typedef struct packed {
        logic [hsvrgb_pkg::CH_W-1:0] brightness;
        logic [hsvrgb_pkg::CH_W-1:0] saturation;
        logic [HUE_W-1:0]            hue;
    } hsv_pixel_t;

    // One output pixel, laid out as on m_tdata
    typedef struct packed {
        logic [hsvrgb_pkg::CH_W-1:0] blue;
        logic [hsvrgb_pkg::CH_W-1:0] green;
        logic [hsvrgb_pkg::CH_W-1:0] red;
    } rgb_pixel_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_DW-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [23:0]      m_tdata;

    rgb_pixel_t rgb_expected[$];
    int         mismatch_count = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;

    hsv_to_rgb_pixel_convert_top #(
        .HUE_BITS (HUE_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Saturate a channel value at full scale
    function automatic logic [hsvrgb_pkg::CH_W-1:0] sat_channel(input longint unsigned x);
        return (x > hsvrgb_pkg::CH_MAX) ? hsvrgb_pkg::CH_MAX : x[hsvrgb_pkg::CH_W-1:0];
    endfunction

    // Six-sector conversion, exact integer arithmetic truncated toward zero
    function automatic rgb_pixel_t predict_rgb(input hsv_pixel_t px);
        longint unsigned      v, s, hue_x6, frac, den, p, q, t, r, g, b;
        hsvrgb_pkg::sector_t  sector;
        rgb_pixel_t           c;
        v = px.brightness;
        s = px.saturation;
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            hue_x6 = longint'(px.hue) * 6;
            sector = hsvrgb_pkg::sector_t'(hue_x6 >> HUE_W);
            frac   = hue_x6 & (HUE_ONE - 1);
            den    = 255 * longint'(HUE_ONE);
            p      = (v * (255 - s)) / 255;
            q      = (v * (den - s * frac)) / den;
            t      = (v * (den - s * (HUE_ONE - frac))) / den;
            case (sector)
                hsvrgb_pkg::SECTOR_RED_YEL: begin r = v; g = t; b = p; end
                hsvrgb_pkg::SECTOR_YEL_GRN: begin r = q; g = v; b = p; end
                hsvrgb_pkg::SECTOR_GRN_CYN: begin r = p; g = v; b = t; end
                hsvrgb_pkg::SECTOR_CYN_BLU: begin r = p; g = q; b = v; end
                hsvrgb_pkg::SECTOR_BLU_MAG: begin r = t; g = p; b = v; end
                default:                    begin r = v; g = p; b = q; end
            endcase
        end
        c.red   = sat_channel(r);
        c.green = sat_channel(g);
        c.blue  = sat_channel(b);
        return c;
    endfunction

    // Print one error line and count it; quiet after the first few dozen
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Send one pixel beat after optional idle cycles; queue its RGB result
    task automatic send_pixel(input hsv_pixel_t px);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DW'(px);
        do @(posedge aclk); while (!s_tready);
        rgb_expected.push_back(predict_rgb(px));
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (rgb_expected.size() != 0) @(posedge aclk);
    endtask

    // Random pixel, biased toward gray, full saturation, full value and sector edges
    function automatic hsv_pixel_t random_pixel();
        hsv_pixel_t px;
        int         k;
        px.hue        = HUE_W'($urandom);
        px.saturation = hsvrgb_pkg::CH_W'($urandom);
        px.brightness = hsvrgb_pkg::CH_W'($urandom);
        case ($urandom_range(11))
            0: px.saturation = '0;
            1: px.saturation = hsvrgb_pkg::CH_MAX;
            2: px.brightness = hsvrgb_pkg::CH_MAX;
            3: begin
                k = $urandom_range(6);
                px.hue = HUE_W'((k * HUE_ONE + 5) / 6 + $urandom_range(4) - 2);
            end
            default: ;
        endcase
        return px;
    endfunction

    // Directed: hue ends, both sides of every sector edge, channel extremes
    task automatic test_sector_edges();
        hsv_pixel_t px;
        int         h;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_pixel('{brightness: 8'd0,   saturation: 8'd0,   hue: '0});
        send_pixel('{brightness: 8'd255, saturation: 8'd0,   hue: '1});
        send_pixel('{brightness: 8'd128, saturation: 8'd0,   hue: 16'h5555});
        send_pixel('{brightness: 8'd255, saturation: 8'd255, hue: '0});
        send_pixel('{brightness: 8'd255, saturation: 8'd255, hue: '1});
        send_pixel('{brightness: 8'd0,   saturation: 8'd255, hue: 16'h8000});
        send_pixel('{brightness: 8'd255, saturation: 8'd1,   hue: 16'h2000});
        send_pixel('{brightness: 8'd1,   saturation: 8'd254, hue: 16'hC000});
        for (int k = 1; k < 6; k++) begin
            h = (k * HUE_ONE + 5) / 6;
            px.saturation = hsvrgb_pkg::CH_MAX;
            px.brightness = hsvrgb_pkg::CH_MAX;
            px.hue = HUE_W'(h - 1);
            send_pixel(px);
            px.hue = HUE_W'(h);
            px.saturation = 8'd200;
            px.brightness = 8'd77;
            send_pixel(px);
        end
        wait_drained();
    endtask

    // Random stream with the given sender idle and receiver stall rates
    task automatic test_stream(input int idle_pct, input int stall_pct, input int count);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_pixel(random_pixel());
        wait_drained();
    endtask

    // Receiver: stall at the phase's rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        rgb_pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rgb_pixel_t'(m_tdata);
            if (rgb_expected.size() == 0) begin
                report_mismatch($sformatf("result beat %06h with none pending", m_tdata));
            end else begin
                want = rgb_expected.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("red got %0d want %0d", got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("green got %0d want %0d", got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.blue));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sector_edges();
        test_stream(0, 0, 300);
        test_stream(57, 0, 300);
        test_stream(0, 57, 300);
        test_stream(23, 23, 300);
        // Let any stray beat surface before the verdict
        repeat (4 * hsvrgb_pkg::NUM_STAGES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("hsv_to_rgb_pixel_convert_top: match");
        end else begin
            $display("hsv_to_rgb_pixel_convert_top: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("hsv_to_rgb_pixel_convert_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
